// ===== sv/ptt_pkg.sv =====
// Package for the polled timer table: sizes, item codes and shared types.
// No dependencies.
package ptt_pkg;

  localparam int NumTimers = 16;
  localparam int IdxW      = (NumTimers > 1) ? $clog2(NumTimers) : 1;
  localparam int CntW      = $clog2(NumTimers + 1);

  typedef enum logic [1:0] {
    ModeAdd  = 2'd0,
    ModeDel  = 2'd1,
    ModeClr  = 2'd2,
    ModePoll = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    KindAdded   = 3'd0,
    KindFull    = 3'd1,
    KindDeleted = 3'd2,
    KindDelErr  = 3'd3,
    KindCleared = 3'd4,
    KindExpired = 3'd5,
    KindDone    = 3'd6
  } kind_e;

  typedef struct packed {
    kind_e      kind;
    logic [5:0] slot;
    logic       last;
  } res_t;

  typedef struct packed {
    logic        one_shot;
    logic [31:0] interval;
    logic [31:0] deadline;
  } ent_t;

  localparam int EntW = $bits(ent_t);

endpackage

// ===== sv/ptt_if.sv =====
// Valid/ready channels for input items and result items.
// Depends on nothing.
interface ptt_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [31:0] now_ms;
  logic [31:0] interval_ms;
  logic        one_shot;
  logic [5:0]  slot_id;

  modport source (output valid, mode, now_ms, interval_ms, one_shot, slot_id, input ready);
  modport sink   (input valid, mode, now_ms, interval_ms, one_shot, slot_id, output ready);
endinterface

interface ptt_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] kind;
  logic [5:0] slot;
  logic       last;

  modport source (output valid, kind, slot, last, input ready);
  modport sink   (input valid, kind, slot, last, output ready);
endinterface

// ===== sv/ptt_ram.sv =====
// Generic single-write, single-read synchronous RAM, registered read data.
// No dependencies.
module ptt_ram #(
  parameter int Depth = 16,
  parameter int Width = 8,
  parameter int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/ptt_ctrl.sv =====
// Timer table sequencer: used bits, add/delete/clear, and the poll scan
// over the entry RAM. Depends on ptt_pkg and ptt_if.
module ptt_ctrl import ptt_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  ptt_in_if.sink          in_i,
  input  logic            push_ok_i,
  output logic            res_valid_o,
  output res_t            res_o,
  output logic            ram_we_o,
  output logic [IdxW-1:0] ram_waddr_o,
  output ent_t            ram_wdata_o,
  output logic            ram_re_o,
  output logic [IdxW-1:0] ram_raddr_o,
  input  ent_t            ram_rdata_i
);

  localparam logic StIdle = 1'b0;
  localparam logic StPoll = 1'b1;
  localparam logic [5:0] NumSlots = 6'(NumTimers);

  logic                 state_q, state_d;
  logic [NumTimers-1:0] used_q, used_d;
  logic [CntW-1:0]      rd_idx_q, rd_idx_d;
  logic [IdxW-1:0]      proc_idx_q, proc_idx_d;
  logic                 pend_q, pend_d;
  logic [31:0]          now_q, now_d;

  logic            accept;
  logic            free_found;
  logic [IdxW-1:0] free_idx;
  logic            sid_ok;
  logic [IdxW-1:0] sid_idx;

  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = NumTimers - 1; i >= 0; i--) begin
      if (!used_q[i]) begin
        free_found = 1'b1;
        free_idx   = IdxW'(i);
      end
    end
  end

  assign sid_ok  = (in_i.slot_id < NumSlots);
  assign sid_idx = in_i.slot_id[IdxW-1:0];

  assign in_i.ready = (state_q == StIdle) && push_ok_i;
  assign accept     = in_i.valid && in_i.ready;

  always_comb begin
    state_d     = state_q;
    used_d      = used_q;
    rd_idx_d    = rd_idx_q;
    proc_idx_d  = proc_idx_q;
    pend_d      = pend_q;
    now_d       = now_q;
    res_valid_o = 1'b0;
    res_o       = '{kind: KindDone, slot: 6'd0, last: 1'b1};
    ram_we_o    = 1'b0;
    ram_waddr_o = '0;
    ram_wdata_o = ram_rdata_i;
    ram_re_o    = 1'b0;
    ram_raddr_o = '0;

    unique case (state_q)
      StIdle: begin
        if (accept) begin
          res_valid_o = 1'b1;
          unique case (in_i.mode)
            ModeAdd: begin
              if (free_found) begin
                ram_we_o    = 1'b1;
                ram_waddr_o = free_idx;
                ram_wdata_o = '{one_shot: in_i.one_shot, interval: in_i.interval_ms,
                                deadline: in_i.now_ms + in_i.interval_ms};
                used_d[free_idx] = 1'b1;
                res_o = '{kind: KindAdded, slot: 6'(free_idx), last: 1'b1};
              end else begin
                res_o = '{kind: KindFull, slot: 6'd0, last: 1'b1};
              end
            end
            ModeDel: begin
              if (sid_ok && used_q[sid_idx]) begin
                used_d[sid_idx] = 1'b0;
                res_o = '{kind: KindDeleted, slot: 6'd0, last: 1'b1};
              end else begin
                res_o = '{kind: KindDelErr, slot: 6'd0, last: 1'b1};
              end
            end
            ModeClr: begin
              used_d = '0;
              res_o  = '{kind: KindCleared, slot: 6'd0, last: 1'b1};
            end
            ModePoll: begin
              res_valid_o = 1'b0;
              now_d       = in_i.now_ms;
              ram_re_o    = 1'b1;
              ram_raddr_o = '0;
              proc_idx_d  = '0;
              rd_idx_d    = CntW'(1);
              pend_d      = 1'b1;
              state_d     = StPoll;
            end
            default: ;
          endcase
        end
      end
      StPoll: begin
        if (push_ok_i) begin
          if (pend_q) begin
            if (used_q[proc_idx_q] && (now_q >= ram_rdata_i.deadline)) begin
              res_valid_o = 1'b1;
              res_o = '{kind: KindExpired, slot: 6'(proc_idx_q), last: 1'b0};
              if (ram_rdata_i.one_shot) begin
                used_d[proc_idx_q] = 1'b0;
              end else begin
                ram_we_o    = 1'b1;
                ram_waddr_o = proc_idx_q;
                ram_wdata_o = '{one_shot: 1'b0, interval: ram_rdata_i.interval,
                                deadline: now_q + ram_rdata_i.interval};
              end
            end
            if (rd_idx_q < CntW'(NumTimers)) begin
              ram_re_o    = 1'b1;
              ram_raddr_o = rd_idx_q[IdxW-1:0];
              proc_idx_d  = rd_idx_q[IdxW-1:0];
              rd_idx_d    = rd_idx_q + CntW'(1);
              pend_d      = 1'b1;
            end else begin
              pend_d = 1'b0;
            end
          end else begin
            res_valid_o = 1'b1;
            res_o       = '{kind: KindDone, slot: 6'd0, last: 1'b1};
            state_d     = StIdle;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StIdle;
      used_q     <= '0;
      rd_idx_q   <= '0;
      proc_idx_q <= '0;
      pend_q     <= 1'b0;
    end else begin
      state_q    <= state_d;
      used_q     <= used_d;
      rd_idx_q   <= rd_idx_d;
      proc_idx_q <= proc_idx_d;
      pend_q     <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    now_q <= now_d;
  end

endmodule

// ===== sv/polled_timer_table.sv =====
// Polled timer table top level: entry RAM, sequencer and output register.
// For add, delete and clear the result is valid the cycle after the item is accepted.
// A poll reads the RAM once per slot, in slot order, and then gives the done result;
// the scan is paced by the single RAM read port and stalls while the output is held.
// Reset (asynchronous, active low) frees every slot; the RAM needs no clearing.
// Depends on ptt_pkg, ptt_if, ptt_ram and ptt_ctrl.
module polled_timer_table import ptt_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  ptt_in_if.sink    in_i,
  ptt_out_if.source out_o
);

  logic            push_ok;
  logic            res_valid;
  res_t            res;
  logic            ram_we;
  logic [IdxW-1:0] ram_waddr;
  ent_t            ram_wdata;
  logic            ram_re;
  logic [IdxW-1:0] ram_raddr;
  ent_t            ram_rdata;

  logic out_valid_q, out_valid_d;
  res_t out_res_q;

  ptt_ram #(
    .Depth (NumTimers),
    .Width (EntW),
    .AddrW (IdxW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  ptt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .push_ok_i   (push_ok),
    .res_valid_o (res_valid),
    .res_o       (res),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata)
  );

  assign push_ok = !out_valid_q || out_o.ready;

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_valid) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      out_res_q <= res;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.kind  = out_res_q.kind;
  assign out_o.slot  = out_res_q.slot;
  assign out_o.last  = out_res_q.last;

endmodule

// ===== test/tb_top.sv =====
// Self-checking bench for polled_timer_table: directed table, then random add/delete/clear/poll.
// Depends on ptt_pkg, ptt_if and polled_timer_table.
module tb_top;
  import ptt_pkg::*;

  typedef struct {
    mode_e       mode;
    logic [31:0] now_ms;
    logic [31:0] interval_ms;
    logic        one_shot;
    logic [5:0]  slot_id;
  } timer_cmd_t;

  typedef struct {
    mode_e       mode;
    logic [31:0] now_ms;
    logic [31:0] interval_ms;
    logic        one_shot;
    logic [5:0]  slot_id;
    int          rep;
    bit          typed;
    kind_e       kind;
    logic [5:0]  slot;
  } dir_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  always #5 clk_i = ~clk_i;

  ptt_in_if  in_if ();
  ptt_out_if out_if ();

  polled_timer_table dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  bit        tmr_used [NumTimers];
  bit        tmr_once [NumTimers];
  bit [31:0] tmr_ival [NumTimers];
  bit [31:0] tmr_dl   [NumTimers];

  res_t     timer_results_q [$];
  int       n_fail = 0;
  dir_row_t dir_tbl [$];

  function automatic res_t mk_res(kind_e k, int s, bit l);
    res_t r;
    r.kind = k;
    r.slot = 6'(s);
    r.last = l;
    return r;
  endfunction

  task automatic free_timer(input int s);
    tmr_used[s] = 1'b0;
    tmr_once[s] = 1'b0;
    tmr_ival[s] = '0;
    tmr_dl[s]   = '0;
  endtask

  task automatic predict_timer_results(input timer_cmd_t c);
    bit found;
    int sid;
    found = 1'b0;
    sid   = int'(c.slot_id);
    case (c.mode)
      ModeAdd: begin
        for (int s = 0; s < NumTimers; s++) begin
          if (!found && !tmr_used[s]) begin
            tmr_used[s] = 1'b1;
            tmr_once[s] = c.one_shot;
            tmr_ival[s] = c.interval_ms;
            tmr_dl[s]   = c.now_ms + c.interval_ms;
            timer_results_q.push_back(mk_res(KindAdded, s, 1'b1));
            found = 1'b1;
          end
        end
        if (!found) timer_results_q.push_back(mk_res(KindFull, 0, 1'b1));
      end
      ModeDel: begin
        if (sid < NumTimers && tmr_used[sid]) begin
          free_timer(sid);
          timer_results_q.push_back(mk_res(KindDeleted, 0, 1'b1));
        end else begin
          timer_results_q.push_back(mk_res(KindDelErr, 0, 1'b1));
        end
      end
      ModeClr: begin
        for (int s = 0; s < NumTimers; s++) free_timer(s);
        timer_results_q.push_back(mk_res(KindCleared, 0, 1'b1));
      end
      default: begin
        for (int s = 0; s < NumTimers; s++) begin
          if (tmr_used[s] && c.now_ms >= tmr_dl[s]) begin
            timer_results_q.push_back(mk_res(KindExpired, s, 1'b0));
            if (tmr_once[s]) free_timer(s);
            else tmr_dl[s] = c.now_ms + tmr_ival[s];
          end
        end
        timer_results_q.push_back(mk_res(KindDone, 0, 1'b1));
      end
    endcase
  endtask

  // idle-free stretch on the first 10 of every 32 items
  task automatic send_cmd(input timer_cmd_t c, input int idx);
    int gap;
    gap = ((idx % 32) < 10) ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid       <= 1'b1;
    in_if.mode        <= c.mode;
    in_if.now_ms      <= c.now_ms;
    in_if.interval_ms <= c.interval_ms;
    in_if.one_shot    <= c.one_shot;
    in_if.slot_id     <= c.slot_id;
    do @(posedge clk_i); while (in_if.ready !== 1'b1);
    predict_timer_results(c);
  endtask

  function automatic timer_cmd_t rand_cmd(inout logic [31:0] tick);
    timer_cmd_t c;
    int r;
    r             = $urandom_range(0, 99);
    c.now_ms      = $urandom;
    c.interval_ms = $urandom;
    c.one_shot    = 1'($urandom_range(0, 1));
    c.slot_id     = 6'($urandom_range(0, 63));
    if (r < 40) begin
      c.mode = ModeAdd;
      if ($urandom_range(0, 9) != 0) c.now_ms = tick;
      if ($urandom_range(0, 4) != 0) c.interval_ms = 32'($urandom_range(0, 300));
    end else if (r < 58) begin
      c.mode = ModeDel;
      if ($urandom_range(0, 4) != 0) c.slot_id = 6'($urandom_range(0, NumTimers - 1));
    end else if (r < 61) begin
      c.mode = ModeClr;
    end else begin
      c.mode = ModePoll;
      tick   = tick + 32'($urandom_range(0, 250));
      if ($urandom_range(0, 9) != 0) c.now_ms = tick;
    end
    return c;
  endfunction

  initial begin : stimulus
    timer_cmd_t  cmd;
    int          n_sent;
    logic [31:0] tick;
    n_sent            = 0;
    rst_ni            <= 1'b0;
    in_if.valid       <= 1'b0;
    in_if.mode        <= ModeAdd;
    in_if.now_ms      <= '0;
    in_if.interval_ms <= '0;
    in_if.one_shot    <= 1'b0;
    in_if.slot_id     <= '0;
    dir_tbl = '{
      '{ModePoll, 32'd0,          32'd0,          1'b0, 6'd0,  1,  1'b1, KindDone,    6'd0},
      '{ModeDel,  32'd0,          32'd0,          1'b0, 6'd0,  1,  1'b1, KindDelErr,  6'd0},
      '{ModeDel,  32'hFFFF_FFFF,  32'hFFFF_FFFF,  1'b1, 6'd63, 1,  1'b1, KindDelErr,  6'd0},
      '{ModeDel,  32'd0,          32'd0,          1'b0, 6'd16, 1,  1'b1, KindDelErr,  6'd0},
      '{ModeAdd,  32'hFFFF_FFFF,  32'hFFFF_FFFF,  1'b1, 6'd63, 1,  1'b1, KindAdded,   6'd0},
      '{ModeAdd,  32'd0,          32'd0,          1'b0, 6'd0,  1,  1'b1, KindAdded,   6'd1},
      '{ModeAdd,  32'd10,         32'd5,          1'b1, 6'd0,  1,  1'b1, KindAdded,   6'd2},
      // deadline wraps past zero
      '{ModeAdd,  32'hFFFF_FFF0,  32'h20,         1'b0, 6'd0,  1,  1'b1, KindAdded,   6'd3},
      '{ModePoll, 32'h10,         32'd0,          1'b0, 6'd0,  1,  1'b0, KindDone,    6'd0},
      '{ModePoll, 32'hFFFF_FFFF,  32'd0,          1'b0, 6'd0,  1,  1'b0, KindDone,    6'd0},
      '{ModeAdd,  32'd100,        32'h8000_0000,  1'b1, 6'd0,  14, 1'b0, KindAdded,   6'd0},
      '{ModeAdd,  32'd0,          32'd0,          1'b0, 6'd0,  1,  1'b1, KindFull,    6'd0},
      // every slot expires
      '{ModePoll, 32'hFFFF_FFFF,  32'hFFFF_FFFF,  1'b1, 6'd63, 1,  1'b0, KindDone,    6'd0},
      '{ModeDel,  32'd0,          32'd0,          1'b0, 6'd1,  1,  1'b1, KindDeleted, 6'd0},
      '{ModeDel,  32'd0,          32'd0,          1'b0, 6'd1,  1,  1'b1, KindDelErr,  6'd0},
      '{ModeClr,  32'd0,          32'd0,          1'b0, 6'd0,  1,  1'b1, KindCleared, 6'd0},
      '{ModePoll, 32'd0,          32'd0,          1'b0, 6'd0,  1,  1'b1, KindDone,    6'd0},
      '{ModeAdd,  32'd5,          32'd7,          1'b0, 6'd0,  1,  1'b1, KindAdded,   6'd0}
    };
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tbl[i]) begin
      for (int k = 0; k < dir_tbl[i].rep; k++) begin
        cmd.mode        = dir_tbl[i].mode;
        cmd.now_ms      = dir_tbl[i].now_ms;
        cmd.interval_ms = dir_tbl[i].interval_ms;
        cmd.one_shot    = dir_tbl[i].one_shot;
        cmd.slot_id     = dir_tbl[i].slot_id;
        send_cmd(cmd, n_sent);
        n_sent++;
        if (dir_tbl[i].typed) begin
          void'(timer_results_q.pop_back());
          timer_results_q.push_back(mk_res(dir_tbl[i].kind, int'(dir_tbl[i].slot), 1'b1));
        end
      end
    end

    tick = ($urandom_range(0, 3) == 0) ? 32'hFFFF_F000 : 32'd0;
    for (int i = 0; i < 80; i++) begin
      cmd = rand_cmd(tick);
      send_cmd(cmd, n_sent);
      n_sent++;
    end
    in_if.valid <= 1'b0;

    while (timer_results_q.size() != 0) @(posedge clk_i);
    repeat (NumTimers + 8) @(posedge clk_i);
    if (n_fail == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin : result_check
    int   stall;
    int   n_rx;
    res_t want;
    n_rx = 0;
    out_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = ((n_rx % 40) < 12) ? 0 : $urandom_range(0, 11);
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk_i); while (out_if.valid !== 1'b1);
      if (timer_results_q.size() == 0) begin
        n_fail++;
        if (n_fail <= 10)
          $display("result %0d unexpected: kind %0d slot %0d last %0d",
                   n_rx, out_if.kind, out_if.slot, out_if.last);
      end else begin
        want = timer_results_q.pop_front();
        if (out_if.kind !== want.kind || out_if.slot !== want.slot ||
            out_if.last !== want.last) begin
          n_fail++;
          if (n_fail <= 10)
            $display({"result %0d: expected kind %0d slot %0d last %0d, ",
                      "got kind %0d slot %0d last %0d"},
                     n_rx, want.kind, want.slot, want.last,
                     out_if.kind, out_if.slot, out_if.last);
        end
      end
      n_rx++;
    end
  end

  initial begin : watchdog
    #4_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

// ===== sim.f =====
sv/ptt_pkg.sv
sv/ptt_if.sv
sv/ptt_ram.sv
sv/ptt_ctrl.sv
sv/polled_timer_table.sv
test/tb_top.sv
